### src/assert_macros.svh
// Assertion macros used by the checker file, xrs_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds at every rising edge outside reset.
`define XRS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("xrs assertion failed");

// Assert that an expression is never true outside reset.
`define XRS_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("xrs forbidden condition seen");

`endif

### src/xrs_pkg.sv
// Package for the xoroshiro128++ generator: opcodes, constants, unit request
// structs and the jump table. Depends on nothing.
package xrs_pkg;

	localparam logic [2:0] OP_SEED_MIX  = 3'd0;
	localparam logic [2:0] OP_SEED_PAIR = 3'd1;
	localparam logic [2:0] OP_BITS      = 3'd2;
	localparam logic [2:0] OP_BOUND     = 3'd3;
	localparam logic [2:0] OP_LONG      = 3'd4;
	localparam logic [2:0] OP_JUMP      = 3'd5;

	localparam logic [63:0] SEED_XOR_K   = 64'h6A09E667F3BCC909;
	localparam logic [63:0] GOLDEN_K     = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_K1       = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_K2       = 64'h94D049BB133111EB;
	localparam logic [63:0] DEFAULT_LOW  = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] DEFAULT_HIGH = 64'h6A09E667F3BCC909;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        start;
		logic [30:0] dividend;
		logic [30:0] divisor;
	} rem_req_t;

	// Jump table entry: {high mask, low mask}.
	function automatic logic [127:0] jump_entry(input logic [6:0] idx);
		logic [127:0] e;
		unique case (idx)
			7'd0: e = {64'hbea1cb0e235828b3, 64'h9729b1f34956cf87};
			7'd1: e = {64'h30d9b3a637b8cc30, 64'h69438152e6e4137b};
			7'd2: e = {64'hef9ba2a91df9826a, 64'h54d7aa11544d7f0d};
			7'd3: e = {64'h6b77a2a23f77b567, 64'h184dd2690f183868};
			7'd4: e = {64'h8ee1a0478680083a, 64'h66cb946dcd298822};
			7'd5: e = {64'h7396c0e3bb0fca9a, 64'h715a6f94782b3af2};
			7'd6: e = {64'h9386458f6709c14a, 64'ha57b30c71d13dd35};
			7'd7: e = {64'h77b6ca6dbf1381b0, 64'h860757166f353f18};
			7'd8: e = {64'he98f1e3a0e68ee6b, 64'h2eb84f434773c0f0};
			7'd9: e = {64'h48a8feb481412058, 64'h6ec4a811d3f5e13a};
			7'd10: e = {64'h2acb074fd1528435, 64'h310cb9f1bb763692};
			7'd11: e = {64'h07cfecc893741e1e, 64'h54445aa20b269e02};
			7'd12: e = {64'h175f9549f77a39ad, 64'he9066c93af9dfdb0};
			7'd13: e = {64'h4426c48954682e38, 64'h62c2b5e8e0d69c9b};
			7'd14: e = {64'h06eeb208c90ce28c, 64'h5e5ef7e00ed35ea9};
			7'd15: e = {64'hb20ad12841018041, 64'hb1b3fcfb522ae01b};
			7'd16: e = {64'hf94466f60cc9cfd9, 64'hfc7cf254b6da0494};
			7'd17: e = {64'h7420dd36650b4e03, 64'he6ee807dd4f693c4};
			7'd18: e = {64'ha4d5e84842496c56, 64'h7ae8e208f7190436};
			7'd19: e = {64'h0a1651d2513089ca, 64'hd1ea97de107b32c9};
			7'd20: e = {64'hfa7bfb681850a9a3, 64'h5f5291a6283d5e3b};
			7'd21: e = {64'hef063377f32c1b27, 64'he075e04ebb0cd1a4};
			7'd22: e = {64'h8ee415201f9ac0d7, 64'h4a94290c864c26ab};
			7'd23: e = {64'h59d29bb6ecd74a35, 64'h5e5ddf9a3ab76ecc};
			7'd24: e = {64'h70d37d8062ede900, 64'h80b8f5bd4f4296e2};
			7'd25: e = {64'hc325d770d103a272, 64'h14babf1d5d7b1bf1};
			7'd26: e = {64'h1386ef197be907e6, 64'hfe7068c56f7362b3};
			7'd27: e = {64'h378500ecc90a9cf1, 64'hd22c04459a7949c0};
			7'd28: e = {64'hfe49609deaa81ae4, 64'h45f33f678cfa46df};
			7'd29: e = {64'hc8df216f835c4cdc, 64'h0cbf3a8b7a964ff5};
			7'd30: e = {64'hadf96f98af5a1ec9, 64'hb0c0a793d68846d9};
			7'd31: e = {64'h814f25287c709c9b, 64'h148a61faa04a5b72};
			7'd32: e = {64'he0165b6fcb8e09f0, 64'ha500b82a5dd0442f};
			7'd33: e = {64'ha559a881ba91e661, 64'h4ab3bd9ea43a43fc};
			7'd34: e = {64'h828686ae4bf3b1e7, 64'h10a26e2069b47539};
			7'd35: e = {64'h354a4970c3798857, 64'h6617a2470d9126f2};
			7'd36: e = {64'h627399b8aeff223b, 64'hc8cb1f7ff71d7799};
			7'd37: e = {64'hf5dc48949583aab8, 64'hf5da697d4650b5b4};
			7'd38: e = {64'h20b68ce2799464a4, 64'haed50dfa8e1f2c0a};
			7'd39: e = {64'h6ce16fa557508398, 64'h00621d3359224c5d};
			7'd40: e = {64'hf5437e0d460fb080, 64'hdd0d3cab187ad8cd};
			7'd41: e = {64'h5a6784625179eb67, 64'h0a7dff3ceca8340a};
			7'd42: e = {64'h5bada798d37bf1da, 64'h66c0ea498ae30744};
			7'd43: e = {64'hf49f3202af8b828d, 64'h9649d0792a7c0f4d};
			7'd44: e = {64'h06a6f88edfd5f696, 64'hdc21a06b0df2c4d7};
			7'd45: e = {64'ha958de14f8755f8e, 64'h5c36949458eb5ff4};
			7'd46: e = {64'hf41b985d37852aca, 64'h67840ae2d8980411};
			7'd47: e = {64'h0889eabc540cb5fc, 64'h1002322c32d607c3};
			7'd48: e = {64'h2df8ffea481d069a, 64'hd08621bb396c6752};
			7'd49: e = {64'h323e4d1e502fcc2e, 64'hd677a3a5fbcf0701};
			7'd50: e = {64'h2a1b5a014f1e28d6, 64'h8fbc61e11fb583e8};
			7'd51: e = {64'h79920c49fc2295fe, 64'h1eb45493f04b9382};
			7'd52: e = {64'ha6f2980b77654919, 64'hd5706cc1e0b7274e};
			7'd53: e = {64'h49242973f0d38bc5, 64'hbaae62ca0da195ee};
			7'd54: e = {64'h5bb41874775c1cf5, 64'h9a1086f162376218};
			7'd55: e = {64'ha1c27475a00c0d56, 64'h5182ac806d5cecef};
			7'd56: e = {64'hfa8abd84ca3bf283, 64'hfb2ef04531097121};
			7'd57: e = {64'hca58f43d9cb60c51, 64'hac19179c3d689655};
			7'd58: e = {64'h4a258cc0cdea0d50, 64'hed43af5dd7af7acc};
			7'd59: e = {64'hcc1823d552f2c042, 64'h468128efb2d5f96c};
			7'd60: e = {64'hedc3c15e60d7a055, 64'hb25a4a5386305762};
			7'd61: e = {64'h9b3edfebd022f75f, 64'h29041dcb27c38d24};
			7'd62: e = {64'hb4a161f08d70845a, 64'hc64435382757e8c5};
			7'd63: e = {64'h1476f5e55753c1e6, 64'h66d8209886988ee9};
			7'd64: e = {64'h32b37ba8ebcebd21, 64'h19c7c3b6a2248bf0};
			7'd65: e = {64'hac20e08487f30521, 64'h04585f12f71a7a7e};
			7'd66: e = {64'h3a04800b2f57d6c2, 64'h4361d754ffc3ef3a};
			7'd67: e = {64'h9116ff8703a2fde4, 64'h94781ed65ce4f05c};
			7'd68: e = {64'hc8bf201295aa0187, 64'h2dada86c4c4116a0};
			7'd69: e = {64'h169d177d72e1cf6e, 64'h6190775f0a84b841};
			7'd70: e = {64'h6dc7ddf8aef47810, 64'h5bfa7ddac8c92335};
			7'd71: e = {64'hb2892a43430ef64e, 64'he0879f073b8390aa};
			7'd72: e = {64'h935baac54121cfc4, 64'h9f0c3ea0adb5a286};
			7'd73: e = {64'h0ea8518bf879a5ef, 64'hf664d22a0895a881};
			7'd74: e = {64'h8ba56f98f2cc4f7a, 64'hbf4ed50a596ac088};
			7'd75: e = {64'heef21af06e0a0185, 64'hb003a9c42a64947f};
			7'd76: e = {64'h9fb641777d5b0d1e, 64'h63c0cd54965137be};
			7'd77: e = {64'h0a06c702e598e322, 64'hfbeaf3c81b304e89};
			7'd78: e = {64'h1a5ba9c2663dd33f, 64'h37d7f24be68d314f};
			7'd79: e = {64'hbb27059694afd248, 64'h8d1ca37e6d9802f0};
			7'd80: e = {64'hfa53f67a95decced, 64'h84e7a1db22563dc3};
			7'd81: e = {64'hf6458473367f4bda, 64'hbb13ff967e38bc8c};
			7'd82: e = {64'h6603c03ffc16d685, 64'h4f459c09fe3c94c6};
			7'd83: e = {64'h085404637907b059, 64'hbba841c7d6560f22};
			7'd84: e = {64'hbf5e11dcbb585d38, 64'haa8bd2b5b259a49b};
			7'd85: e = {64'h8be8ba0509a9e3b1, 64'hf4077d9579ed71c4};
			7'd86: e = {64'h6f1ee9bba817ede4, 64'h5a56ce904aadad43};
			7'd87: e = {64'h64bca8c9658ea667, 64'h85bd0a5b2b1f613e};
			7'd88: e = {64'h9af56039ed5b676b, 64'h7e8ced804a7bf3c1};
			7'd89: e = {64'h605b50115c8471b7, 64'ha2ec7b2e7c4cbcc9};
			7'd90: e = {64'h368afd852e5264ea, 64'hec3d9bb94636cd36};
			7'd91: e = {64'he492beffe8642a2b, 64'h76982087ceeeab85};
			7'd92: e = {64'hb5395b14c2c37815, 64'h4801e76ae6fd6cbb};
			7'd93: e = {64'hd9333173d2a5871e, 64'h8d9d02574584a4bb};
			7'd94: e = {64'h4b407a8076b89d2a, 64'h4661b6902fc7d7be};
			7'd95: e = {64'h0e50bff9ddccb272, 64'h570906b495b01afb};
			7'd96: e = {64'ha05ac64529d282cf, 64'hb5f8c537fd811c76};
			7'd97: e = {64'h4796788837961b7e, 64'h8ceaa8fd64633a67};
			7'd98: e = {64'h826090d1fd6087b9, 64'h034ce4ff7e425e42};
			7'd99: e = {64'hce777c9e109b7000, 64'h18200d9679cc6824};
			7'd100: e = {64'h7f997981adf1dbf1, 64'he7e04d380470b92c};
			7'd101: e = {64'hfa5f51fac197f6ab, 64'h03f57d6bfc05bba6};
			7'd102: e = {64'h813e4a988e6ca307, 64'hc22968d5e4ce50c7};
			7'd103: e = {64'ha39f5ef8fd150cdd, 64'he1c2bc69fe501b1e};
			7'd104: e = {64'h8cb69e62422cb70e, 64'hb4c2fbe82e04a84e};
			7'd105: e = {64'h694ac8fda0855c93, 64'h87c0cdc2253a7269};
			7'd106: e = {64'habaff55f08adaf63, 64'h066b779d29655731};
			7'd107: e = {64'h5fea359b6c9d1814, 64'h97bd79af0dfc9c0a};
			7'd108: e = {64'h17e0a1707ea1201b, 64'hf8a33459217404a2};
			7'd109: e = {64'h00122ea1784a4d19, 64'h00dd88bb0742b4e9};
			7'd110: e = {64'ha81623c9278d8a0d, 64'hfc8078cedc62f651};
			7'd111: e = {64'hb5a03428ac00fd10, 64'h15cb73b6cbbff9d3};
			7'd112: e = {64'h308c609078741ef2, 64'h64ecd8db5c9ff721};
			7'd113: e = {64'hb3afddc877a91684, 64'he8dd2d0bf421b74f};
			7'd114: e = {64'hc4508328c345c028, 64'h566f3dbbc74afc1a};
			7'd115: e = {64'h7b9d7f4dad12a68a, 64'hf349042186423b7c};
			7'd116: e = {64'h43f9aade34df2e55, 64'h6841f59bfec9c94b};
			7'd117: e = {64'hc532c3fa0aadfa0b, 64'haffec201fcb72a07};
			7'd118: e = {64'hdd894f38e24ec479, 64'h6925e83b393340c1};
			7'd119: e = {64'h9815571c6837338c, 64'h08ae87e6f15032e1};
			7'd120: e = {64'h2e34ccc955545d0d, 64'h380e377d081e988a};
			7'd121: e = {64'habb6695499088738, 64'hfa489750820c64b1};
			7'd122: e = {64'hd1fc977813aa97f6, 64'h8e229c3a401cc040};
			7'd123: e = {64'hf33a77ab9e804e16, 64'h84fc15f114c8ffd5};
			7'd124: e = {64'h84774bf7aa07a202, 64'h5cbb3810d96db47a};
			7'd125: e = {64'habd2e2e4517a3793, 64'h61ba8c6be722c83b};
			7'd126: e = {64'hcb76df4453ed7bf3, 64'hf958d44c7154bca9};
			7'd127: e = {64'h4955857644270dc4, 64'hba2b39a94a63bc6f};
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

### src/xrs_mul.sv
// Shared 64x64 multiplier, low 64 bits of the product, one 32x32 partial
// product per cycle. Depends on xrs_pkg.
module xrs_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  xrs_pkg::mul_req_t req,
	output logic              done,
	output logic [63:0]       product
);

	logic [63:0] a_q, b_q, acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q, done_q;
	logic [31:0] op_a, op_b;
	logic [63:0] part;

	always_comb begin
		op_a = (cnt_q == 2'd2) ? a_q[63:32] : a_q[31:0];
		op_b = (cnt_q == 2'd1) ? b_q[63:32] : b_q[31:0];
		part = {32'd0, op_a} * {32'd0, op_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				a_q    <= req.a;
				b_q    <= req.b;
				cnt_q  <= 2'd0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// low x low, then the two cross terms shifted up
				if (cnt_q == 2'd0) begin
					acc_q <= part;
				end else begin
					acc_q <= acc_q + {part[31:0], 32'd0};
				end
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

### src/xrs_rem.sv
// Restoring bit-serial 31-bit remainder unit, one quotient bit per cycle.
// Depends on xrs_pkg.
module xrs_rem (
	input  logic              clk,
	input  logic              arst_n,
	input  xrs_pkg::rem_req_t req,
	output logic              done,
	output logic [30:0]       remainder
);

	logic [30:0] dvd_q, div_q, rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [31:0] trial, diff;

	always_comb begin
		trial = {rem_q, dvd_q[30]};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				dvd_q  <= req.dividend;
				div_q  <= req.divisor;
				rem_q  <= '0;
				cnt_q  <= 5'd0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// subtract where it fits, else keep the shifted remainder
				rem_q <= diff[31] ? trial[30:0] : diff[30:0];
				dvd_q <= {dvd_q[29:0], 1'b0};
				if (cnt_q == 5'd30) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

### src/xoroshiro128pp_generator.sv
// Top level of the xoroshiro128++ generator: state, sequencer, output register.
// Depends on xrs_pkg, xrs_mul and xrs_rem.
//
// Usage: send one command beat on s_* (opcode and operands); exactly one result
// beat comes back on m_*. s_tready is high only while the sequencer is idle, so
// one command is in flight at a time.
// Work from accept to the result register being loaded:
//   seed pair, next bits, bound (power of two or zero), unused opcodes: done in
//     the decode state.
//   next long: two draws through the one step unit.
//   bound, general case: each draw runs through the 31-step remainder unit;
//     rejected draws repeat this.
//   seed mixed: four products on the shared multiplier, in turn, after the
//     decode state.
//   jump: the decode state and then one table entry per cycle.
// Reset: state returns to the default words, the output register empties.
// Stall: while m_tready is low the result holds in the output register; a new
// command is still accepted, and its result waits in a hold register until
// the output register frees.
module xoroshiro128pp_generator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// opcode[2:0], value_a[66:3], value_b[130:67], bit_count[136:131],
	// upper_bound[167:137]
	input  logic [167:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// value[63:0], two's complement
	output logic [63:0]  m_tdata
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_LONG2, ST_MIXA, ST_MIXB, ST_REM, ST_JUMP, ST_FIN
	} state_t;

	state_t      state_q;
	logic [63:0] sl_q, sh_q;
	logic [2:0]  op_q;
	logic [63:0] va_q, vb_q;
	logic [5:0]  bc_q;
	logic [30:0] ub_q;
	logic [63:0] res_q, out_q;
	logic        out_valid_q;
	logic [31:0] top_q;
	logic [30:0] d_q;
	logic        lane_q;
	logic [63:0] xs_q, mix_low_q;
	logic [6:0]  idx_q;
	logic [127:0] acc_q;
	logic        mul_start_q, rem_start_q;
	logic [63:0] mul_a_q, mul_b_q;

	xrs_pkg::mul_req_t mul_req;
	xrs_pkg::rem_req_t rem_req;
	logic        mul_done, rem_done;
	logic [63:0] mul_p;
	logic [30:0] rem_val;

	// one generator step from the current state
	logic [63:0] sum, raw, bx, nl, nh;
	logic [5:0]  nsat;
	logic [63:0] bits_res, long_res, p_m, r_mix, x0;
	logic [30:0] lm1;
	logic        pow2;
	logic [61:0] scale;
	logic [31:0] chk;
	logic        jbit;
	logic [127:0] acc_next;
	logic        out_free, fin_en;
	logic [63:0] fin_val;
	logic        mul_go, rem_go;

	assign mul_req = '{start: mul_start_q, a: mul_a_q, b: mul_b_q};
	assign rem_req = '{start: rem_start_q, dividend: d_q, divisor: ub_q};

	xrs_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .done(mul_done),
		.product(mul_p));
	xrs_rem u_rem (.clk(clk), .arst_n(arst_n), .req(rem_req), .done(rem_done),
		.remainder(rem_val));

	always_comb begin
		sum = sl_q + sh_q;
		raw = {sum[46:0], sum[63:47]} + sl_q;
		bx  = sh_q ^ sl_q;
		nl  = {sl_q[14:0], sl_q[63:15]} ^ bx ^ {bx[42:0], 21'd0};
		nh  = {bx[35:0], bx[63:36]};

		// next bits: clamp the count to 32, sign-extend a full 32-bit draw
		nsat = (bc_q > 6'd32) ? 6'd32 : bc_q;
		if (nsat == 6'd0) begin
			bits_res = '0;
		end else if (nsat == 6'd32) begin
			bits_res = {{32{raw[63]}}, raw[63:32]};
		end else begin
			bits_res = raw >> (7'd64 - {1'b0, nsat});
		end

		long_res = {top_q, 32'd0} + {{32{raw[63]}}, raw[63:32]};

		lm1   = ub_q - 31'd1;
		pow2  = (ub_q & lm1) == 31'd0;
		scale = {31'd0, ub_q} * {31'd0, raw[63:33]};
		chk   = {1'b0, d_q} - {1'b0, rem_val} + {1'b0, lm1};

		p_m   = mul_p;
		r_mix = p_m ^ (p_m >> 31);
		x0    = va_q ^ xrs_pkg::SEED_XOR_K;

		jbit     = idx_q[6] ? sh_q[idx_q[5:0]] : sl_q[idx_q[5:0]];
		acc_next = jbit ? (acc_q ^ xrs_pkg::jump_entry(idx_q)) : acc_q;

		out_free = !out_valid_q || m_tready;

		// start the shared units: first product, next product, first or repeat
		// remainder
		mul_go = ((state_q == ST_EXEC) && (op_q == xrs_pkg::OP_SEED_MIX)) ||
			((state_q == ST_MIXA) && mul_done) ||
			((state_q == ST_MIXB) && mul_done && !lane_q);
		rem_go = ((state_q == ST_EXEC) && (op_q == xrs_pkg::OP_BOUND) && !pow2) ||
			((state_q == ST_REM) && rem_done && chk[31]);

		fin_en  = 1'b0;
		fin_val = '0;
		unique case (state_q)
			ST_EXEC: begin
				unique case (op_q)
					xrs_pkg::OP_SEED_MIX, xrs_pkg::OP_LONG, xrs_pkg::OP_JUMP: fin_en = 1'b0;
					xrs_pkg::OP_BITS: begin
						fin_en  = 1'b1;
						fin_val = bits_res;
					end
					xrs_pkg::OP_BOUND: begin
						fin_en  = pow2;
						fin_val = {33'd0, scale[61:31]};
					end
					default: fin_en = 1'b1;
				endcase
			end
			ST_LONG2: begin
				fin_en  = 1'b1;
				fin_val = long_res;
			end
			ST_MIXB: fin_en = mul_done && lane_q;
			ST_REM: begin
				fin_en  = rem_done && !chk[31];
				fin_val = {33'd0, rem_val};
			end
			ST_JUMP: fin_en = (idx_q == 7'd127);
			ST_FIN: begin
				fin_en  = 1'b1;
				fin_val = res_q;
			end
			default: fin_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sl_q        <= xrs_pkg::DEFAULT_LOW;
			sh_q        <= xrs_pkg::DEFAULT_HIGH;
			out_valid_q <= 1'b0;
			mul_start_q <= 1'b0;
			rem_start_q <= 1'b0;
		end else begin
			mul_start_q <= mul_go;
			rem_start_q <= rem_go;

			// deliver a finished result, or hold it until the output frees
			if (fin_en && out_free) begin
				out_valid_q <= 1'b1;
				out_q       <= fin_val;
				state_q     <= ST_IDLE;
			end else begin
				if (fin_en) begin
					res_q   <= fin_val;
					state_q <= ST_FIN;
				end
				if (m_tready) begin
					out_valid_q <= 1'b0;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tdata[2:0];
						va_q    <= s_tdata[66:3];
						vb_q    <= s_tdata[130:67];
						bc_q    <= s_tdata[136:131];
						ub_q    <= s_tdata[167:137];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (op_q)
						xrs_pkg::OP_SEED_MIX: begin
							xs_q    <= x0 + xrs_pkg::GOLDEN_K;
							lane_q  <= 1'b0;
							mul_a_q <= x0 ^ (x0 >> 30);
							mul_b_q <= xrs_pkg::MIX_K1;
							state_q <= ST_MIXA;
						end
						xrs_pkg::OP_SEED_PAIR: begin
							if ((va_q | vb_q) == 64'd0) begin
								sl_q <= xrs_pkg::DEFAULT_LOW;
								sh_q <= xrs_pkg::DEFAULT_HIGH;
							end else begin
								sl_q <= va_q;
								sh_q <= vb_q;
							end
						end
						xrs_pkg::OP_BITS: begin
							sl_q <= nl;
							sh_q <= nh;
						end
						xrs_pkg::OP_BOUND: begin
							sl_q <= nl;
							sh_q <= nh;
							d_q  <= raw[63:33];
							if (!pow2) begin
								state_q <= ST_REM;
							end
						end
						xrs_pkg::OP_LONG: begin
							sl_q    <= nl;
							sh_q    <= nh;
							top_q   <= raw[63:32];
							state_q <= ST_LONG2;
						end
						xrs_pkg::OP_JUMP: begin
							acc_q   <= '0;
							idx_q   <= 7'd0;
							state_q <= ST_JUMP;
						end
						default: ;
					endcase
				end
				ST_LONG2: begin
					sl_q <= nl;
					sh_q <= nh;
				end
				ST_MIXA: begin
					if (mul_done) begin
						mul_a_q <= p_m ^ (p_m >> 27);
						mul_b_q <= xrs_pkg::MIX_K2;
						state_q <= ST_MIXB;
					end
				end
				ST_MIXB: begin
					if (mul_done) begin
						if (!lane_q) begin
							// low word done; mix the golden-offset seed next
							mix_low_q <= r_mix;
							lane_q    <= 1'b1;
							mul_a_q   <= xs_q ^ (xs_q >> 30);
							mul_b_q   <= xrs_pkg::MIX_K1;
							state_q   <= ST_MIXA;
						end else begin
							sl_q <= mix_low_q;
							sh_q <= r_mix;
						end
					end
				end
				ST_REM: begin
					if (rem_done && chk[31]) begin
						// reject: draw again and restart the remainder
						sl_q <= nl;
						sh_q <= nh;
						d_q  <= raw[63:33];
					end
				end
				ST_JUMP: begin
					acc_q <= acc_next;
					idx_q <= idx_q + 7'd1;
					if (idx_q == 7'd127) begin
						sl_q <= acc_next[63:0];
						sh_q <= acc_next[127:64];
					end
				end
				ST_FIN: ;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

### src/xrs_checker.sv
// Port-level checker for the xoroshiro128++ generator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module xrs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	// a stalled result beat holds
	`XRS_ASSERT(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
	// one command at a time: busy right after a beat is taken
	`XRS_ASSERT(a_busy_after_accept, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready)
	// a new result only appears after a command was being worked on
	`XRS_ASSERT(a_result_from_work, clk, arst_n, $rose(m_tvalid) |-> $past(!s_tready))
	// a new result never rises when s_tready was high at both past samples it checks
	`XRS_NEVER(a_no_result_when_idle_twice, clk, arst_n, $rose(m_tvalid) && $past(s_tready, 2) && $past(s_tready))

endmodule

bind xoroshiro128pp_generator xrs_checker u_xrs_checker (.*);

### bench/tb_xoroshiro128pp_generator.sv
// Self-checking bench for the xoroshiro128++ generator: drives command beats,
// predicts each drawn value and compares it. Depends on xrs_pkg and the top.
`timescale 1ns / 1ps

module tb_xoroshiro128pp_generator;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// opcode[2:0], value_a[66:3], value_b[130:67], bit_count[136:131],
	// upper_bound[167:137]
	logic [167:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// value[63:0], two's complement
	logic [63:0]  m_tdata;

	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	typedef struct {
		logic [2:0]  op;
		logic [63:0] va;
		logic [63:0] vb;
		logic [5:0]  nbits;
		logic [30:0] bound;
		logic        known;
		logic [63:0] fixed;
	} cmd_t;

	logic [63:0] gen_lo, gen_hi;
	logic [63:0] value_queue[$];
	int          errors;
	int          send_idle, recv_idle;
	logic        sending;

	xoroshiro128pp_generator dut (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int k);
		return (x << k) | (x >> (64 - k));
	endfunction

	function automatic logic [63:0] stafford13(input logic [63:0] x);
		x = (x ^ (x >> 30)) * xrs_pkg::MIX_K1;
		x = (x ^ (x >> 27)) * xrs_pkg::MIX_K2;
		return x ^ (x >> 31);
	endfunction

	// Jump masks are kept here as their own copy, {high, low} per state bit.
	logic [127:0] jump_masks[128] = '{
		{64'hbea1cb0e235828b3, 64'h9729b1f34956cf87}, {64'h30d9b3a637b8cc30, 64'h69438152e6e4137b},
		{64'hef9ba2a91df9826a, 64'h54d7aa11544d7f0d}, {64'h6b77a2a23f77b567, 64'h184dd2690f183868},
		{64'h8ee1a0478680083a, 64'h66cb946dcd298822}, {64'h7396c0e3bb0fca9a, 64'h715a6f94782b3af2},
		{64'h9386458f6709c14a, 64'ha57b30c71d13dd35}, {64'h77b6ca6dbf1381b0, 64'h860757166f353f18},
		{64'he98f1e3a0e68ee6b, 64'h2eb84f434773c0f0}, {64'h48a8feb481412058, 64'h6ec4a811d3f5e13a},
		{64'h2acb074fd1528435, 64'h310cb9f1bb763692}, {64'h07cfecc893741e1e, 64'h54445aa20b269e02},
		{64'h175f9549f77a39ad, 64'he9066c93af9dfdb0}, {64'h4426c48954682e38, 64'h62c2b5e8e0d69c9b},
		{64'h06eeb208c90ce28c, 64'h5e5ef7e00ed35ea9}, {64'hb20ad12841018041, 64'hb1b3fcfb522ae01b},
		{64'hf94466f60cc9cfd9, 64'hfc7cf254b6da0494}, {64'h7420dd36650b4e03, 64'he6ee807dd4f693c4},
		{64'ha4d5e84842496c56, 64'h7ae8e208f7190436}, {64'h0a1651d2513089ca, 64'hd1ea97de107b32c9},
		{64'hfa7bfb681850a9a3, 64'h5f5291a6283d5e3b}, {64'hef063377f32c1b27, 64'he075e04ebb0cd1a4},
		{64'h8ee415201f9ac0d7, 64'h4a94290c864c26ab}, {64'h59d29bb6ecd74a35, 64'h5e5ddf9a3ab76ecc},
		{64'h70d37d8062ede900, 64'h80b8f5bd4f4296e2}, {64'hc325d770d103a272, 64'h14babf1d5d7b1bf1},
		{64'h1386ef197be907e6, 64'hfe7068c56f7362b3}, {64'h378500ecc90a9cf1, 64'hd22c04459a7949c0},
		{64'hfe49609deaa81ae4, 64'h45f33f678cfa46df}, {64'hc8df216f835c4cdc, 64'h0cbf3a8b7a964ff5},
		{64'hadf96f98af5a1ec9, 64'hb0c0a793d68846d9}, {64'h814f25287c709c9b, 64'h148a61faa04a5b72},
		{64'he0165b6fcb8e09f0, 64'ha500b82a5dd0442f}, {64'ha559a881ba91e661, 64'h4ab3bd9ea43a43fc},
		{64'h828686ae4bf3b1e7, 64'h10a26e2069b47539}, {64'h354a4970c3798857, 64'h6617a2470d9126f2},
		{64'h627399b8aeff223b, 64'hc8cb1f7ff71d7799}, {64'hf5dc48949583aab8, 64'hf5da697d4650b5b4},
		{64'h20b68ce2799464a4, 64'haed50dfa8e1f2c0a}, {64'h6ce16fa557508398, 64'h00621d3359224c5d},
		{64'hf5437e0d460fb080, 64'hdd0d3cab187ad8cd}, {64'h5a6784625179eb67, 64'h0a7dff3ceca8340a},
		{64'h5bada798d37bf1da, 64'h66c0ea498ae30744}, {64'hf49f3202af8b828d, 64'h9649d0792a7c0f4d},
		{64'h06a6f88edfd5f696, 64'hdc21a06b0df2c4d7}, {64'ha958de14f8755f8e, 64'h5c36949458eb5ff4},
		{64'hf41b985d37852aca, 64'h67840ae2d8980411}, {64'h0889eabc540cb5fc, 64'h1002322c32d607c3},
		{64'h2df8ffea481d069a, 64'hd08621bb396c6752}, {64'h323e4d1e502fcc2e, 64'hd677a3a5fbcf0701},
		{64'h2a1b5a014f1e28d6, 64'h8fbc61e11fb583e8}, {64'h79920c49fc2295fe, 64'h1eb45493f04b9382},
		{64'ha6f2980b77654919, 64'hd5706cc1e0b7274e}, {64'h49242973f0d38bc5, 64'hbaae62ca0da195ee},
		{64'h5bb41874775c1cf5, 64'h9a1086f162376218}, {64'ha1c27475a00c0d56, 64'h5182ac806d5cecef},
		{64'hfa8abd84ca3bf283, 64'hfb2ef04531097121}, {64'hca58f43d9cb60c51, 64'hac19179c3d689655},
		{64'h4a258cc0cdea0d50, 64'hed43af5dd7af7acc}, {64'hcc1823d552f2c042, 64'h468128efb2d5f96c},
		{64'hedc3c15e60d7a055, 64'hb25a4a5386305762}, {64'h9b3edfebd022f75f, 64'h29041dcb27c38d24},
		{64'hb4a161f08d70845a, 64'hc64435382757e8c5}, {64'h1476f5e55753c1e6, 64'h66d8209886988ee9},
		{64'h32b37ba8ebcebd21, 64'h19c7c3b6a2248bf0}, {64'hac20e08487f30521, 64'h04585f12f71a7a7e},
		{64'h3a04800b2f57d6c2, 64'h4361d754ffc3ef3a}, {64'h9116ff8703a2fde4, 64'h94781ed65ce4f05c},
		{64'hc8bf201295aa0187, 64'h2dada86c4c4116a0}, {64'h169d177d72e1cf6e, 64'h6190775f0a84b841},
		{64'h6dc7ddf8aef47810, 64'h5bfa7ddac8c92335}, {64'hb2892a43430ef64e, 64'he0879f073b8390aa},
		{64'h935baac54121cfc4, 64'h9f0c3ea0adb5a286}, {64'h0ea8518bf879a5ef, 64'hf664d22a0895a881},
		{64'h8ba56f98f2cc4f7a, 64'hbf4ed50a596ac088}, {64'heef21af06e0a0185, 64'hb003a9c42a64947f},
		{64'h9fb641777d5b0d1e, 64'h63c0cd54965137be}, {64'h0a06c702e598e322, 64'hfbeaf3c81b304e89},
		{64'h1a5ba9c2663dd33f, 64'h37d7f24be68d314f}, {64'hbb27059694afd248, 64'h8d1ca37e6d9802f0},
		{64'hfa53f67a95decced, 64'h84e7a1db22563dc3}, {64'hf6458473367f4bda, 64'hbb13ff967e38bc8c},
		{64'h6603c03ffc16d685, 64'h4f459c09fe3c94c6}, {64'h085404637907b059, 64'hbba841c7d6560f22},
		{64'hbf5e11dcbb585d38, 64'haa8bd2b5b259a49b}, {64'h8be8ba0509a9e3b1, 64'hf4077d9579ed71c4},
		{64'h6f1ee9bba817ede4, 64'h5a56ce904aadad43}, {64'h64bca8c9658ea667, 64'h85bd0a5b2b1f613e},
		{64'h9af56039ed5b676b, 64'h7e8ced804a7bf3c1}, {64'h605b50115c8471b7, 64'ha2ec7b2e7c4cbcc9},
		{64'h368afd852e5264ea, 64'hec3d9bb94636cd36}, {64'he492beffe8642a2b, 64'h76982087ceeeab85},
		{64'hb5395b14c2c37815, 64'h4801e76ae6fd6cbb}, {64'hd9333173d2a5871e, 64'h8d9d02574584a4bb},
		{64'h4b407a8076b89d2a, 64'h4661b6902fc7d7be}, {64'h0e50bff9ddccb272, 64'h570906b495b01afb},
		{64'ha05ac64529d282cf, 64'hb5f8c537fd811c76}, {64'h4796788837961b7e, 64'h8ceaa8fd64633a67},
		{64'h826090d1fd6087b9, 64'h034ce4ff7e425e42}, {64'hce777c9e109b7000, 64'h18200d9679cc6824},
		{64'h7f997981adf1dbf1, 64'he7e04d380470b92c}, {64'hfa5f51fac197f6ab, 64'h03f57d6bfc05bba6},
		{64'h813e4a988e6ca307, 64'hc22968d5e4ce50c7}, {64'ha39f5ef8fd150cdd, 64'he1c2bc69fe501b1e},
		{64'h8cb69e62422cb70e, 64'hb4c2fbe82e04a84e}, {64'h694ac8fda0855c93, 64'h87c0cdc2253a7269},
		{64'habaff55f08adaf63, 64'h066b779d29655731}, {64'h5fea359b6c9d1814, 64'h97bd79af0dfc9c0a},
		{64'h17e0a1707ea1201b, 64'hf8a33459217404a2}, {64'h00122ea1784a4d19, 64'h00dd88bb0742b4e9},
		{64'ha81623c9278d8a0d, 64'hfc8078cedc62f651}, {64'hb5a03428ac00fd10, 64'h15cb73b6cbbff9d3},
		{64'h308c609078741ef2, 64'h64ecd8db5c9ff721}, {64'hb3afddc877a91684, 64'he8dd2d0bf421b74f},
		{64'hc4508328c345c028, 64'h566f3dbbc74afc1a}, {64'h7b9d7f4dad12a68a, 64'hf349042186423b7c},
		{64'h43f9aade34df2e55, 64'h6841f59bfec9c94b}, {64'hc532c3fa0aadfa0b, 64'haffec201fcb72a07},
		{64'hdd894f38e24ec479, 64'h6925e83b393340c1}, {64'h9815571c6837338c, 64'h08ae87e6f15032e1},
		{64'h2e34ccc955545d0d, 64'h380e377d081e988a}, {64'habb6695499088738, 64'hfa489750820c64b1},
		{64'hd1fc977813aa97f6, 64'h8e229c3a401cc040}, {64'hf33a77ab9e804e16, 64'h84fc15f114c8ffd5},
		{64'h84774bf7aa07a202, 64'h5cbb3810d96db47a}, {64'habd2e2e4517a3793, 64'h61ba8c6be722c83b},
		{64'hcb76df4453ed7bf3, 64'hf958d44c7154bca9}, {64'h4955857644270dc4, 64'hba2b39a94a63bc6f}
	};

	// One xoroshiro128++ step on the bench copy of the state.
	function automatic logic [63:0] step_word();
		logic [63:0] a, b, w;
		a = gen_lo;
		b = gen_hi;
		w = rotl(a + b, 17) + a;
		b ^= a;
		gen_lo = rotl(a, 49) ^ b ^ (b << 21);
		gen_hi = rotl(b, 28);
		return w;
	endfunction

	// Predict the drawn value of one command and advance the bench state.
	function automatic logic [63:0] predict_value(input cmd_t c);
		logic [63:0] x, w, res, acc_l, acc_h, top;
		logic [31:0] lim, lm1, d, q;
		int          n;
		res = '0;
		case (c.op)
			xrs_pkg::OP_SEED_MIX: begin
				x = c.va ^ xrs_pkg::SEED_XOR_K;
				gen_lo = stafford13(x);
				gen_hi = stafford13(x + xrs_pkg::GOLDEN_K);
			end
			xrs_pkg::OP_SEED_PAIR: begin
				gen_lo = c.va;
				gen_hi = c.vb;
				if ((c.va | c.vb) == '0) begin
					gen_lo = xrs_pkg::DEFAULT_LOW;
					gen_hi = xrs_pkg::DEFAULT_HIGH;
				end
			end
			xrs_pkg::OP_BITS: begin
				w = step_word();
				n = (c.nbits > 32) ? 32 : int'(c.nbits);
				if (n != 0) begin
					res = w >> (64 - n);
					if (n == 32 && res[31])
						res[63:32] = '1;
				end
			end
			xrs_pkg::OP_BOUND: begin
				lim = {1'b0, c.bound};
				lm1 = lim - 1;
				d = 32'(step_word() >> 33);
				if ((lim & lm1) == '0) begin
					res = (64'(lim) * 64'(d)) >> 31;
				end else begin
					// Redraw while the wrapped 32-bit window check fails.
					forever begin
						q = d % lim;
						if (((d - q + lm1) & 32'h8000_0000) == '0)
							break;
						d = 32'(step_word() >> 33);
					end
					res = 64'(q);
				end
			end
			xrs_pkg::OP_LONG: begin
				top = step_word() >> 32;
				w = step_word() >> 32;
				if (w[31])
					w[63:32] = '1;
				res = (top << 32) + w;
			end
			xrs_pkg::OP_JUMP: begin
				acc_l = '0;
				acc_h = '0;
				for (int i = 0; i < 128; i++) begin
					if ((i < 64) ? gen_lo[i] : gen_hi[i - 64]) begin
						acc_h ^= jump_masks[i][127:64];
						acc_l ^= jump_masks[i][63:0];
					end
				end
				gen_lo = acc_l;
				gen_hi = acc_h;
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic cmd_t mk(input logic [2:0] op, input logic [63:0] va,
			input logic [63:0] vb, input logic [5:0] nb, input logic [30:0] bd);
		cmd_t c;
		c.op = op;
		c.va = va;
		c.vb = vb;
		c.nbits = nb;
		c.bound = bd;
		c.known = 1'b0;
		c.fixed = '0;
		return c;
	endfunction

	function automatic cmd_t mk_fixed(input cmd_t c, input logic [63:0] v);
		c.known = 1'b1;
		c.fixed = v;
		return c;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly draws, with a few reseeds and the slow ops kept rare.
	function automatic cmd_t random_cmd();
		int          pick;
		logic [30:0] bd;
		logic [5:0]  nb;
		pick = $urandom_range(0, 99);
		nb = (pick % 4 == 0) ? 6'($urandom()) : 6'($urandom_range(0, 32));
		case ($urandom_range(0, 3))
			0: bd = 31'($urandom());
			1: bd = 31'(1) << $urandom_range(0, 30);
			2: bd = 31'($urandom_range(0, 20));
			default: bd = 31'($urandom_range(1, 70000));
		endcase
		if (pick < 3)
			return mk(xrs_pkg::OP_SEED_MIX, rand64(), rand64(), nb, bd);
		if (pick < 8)
			return mk(xrs_pkg::OP_SEED_PAIR, (pick == 7) ? '0 : rand64(),
				(pick == 7) ? '0 : rand64(), nb, bd);
		if (pick < 40)
			return mk(xrs_pkg::OP_BITS, rand64(), rand64(), nb, bd);
		if (pick < 70)
			return mk(xrs_pkg::OP_BOUND, rand64(), rand64(), nb, bd);
		if (pick < 95)
			return mk(xrs_pkg::OP_LONG, rand64(), rand64(), nb, bd);
		if (pick < 97)
			return mk(xrs_pkg::OP_JUMP, rand64(), rand64(), nb, bd);
		return mk((pick == 97) ? OP_SPARE_6 : OP_SPARE_7, rand64(), rand64(), nb, bd);
	endfunction

	// Present one command beat and hold it until the handshake; the caller
	// drops valid after the last beat.
	task automatic send_cmd(input cmd_t c);
		logic [63:0] v;
		while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {c.bound, c.nbits, c.vb, c.va, c.op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		v = predict_value(c);
		if (c.known && v != c.fixed) begin
			$error("table row value mismatch: typed %h, predicted %h", c.fixed, v);
			errors++;
		end
		value_queue.push_back(c.known ? c.fixed : v);
	endtask

	// Receiver: random stalls and in-order comparison.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (value_queue.size() == 0) begin
					$error("value beat with nothing expected: actual %h", m_tdata);
					errors++;
				end else begin
					if (m_tdata !== value_queue[0]) begin
						$error("value mismatch: expected %h, actual %h",
							value_queue[0], m_tdata);
						errors++;
					end
					void'(value_queue.pop_front());
				end
			end
			m_tready <= !(recv_idle > 0 && $urandom_range(0, 99) < recv_idle);
		end
	end

	initial begin
		#3000000;
		$display("xoroshiro128pp_generator regression: fail");
		$finish;
	end

	initial begin
		cmd_t dir[$];
		int   phase;
		errors = 0;
		send_idle = 0;
		recv_idle = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b1;
		gen_lo = xrs_pkg::DEFAULT_LOW;
		gen_hi = xrs_pkg::DEFAULT_HIGH;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: reset state draws, extremes and each special case.
		dir.push_back(mk(xrs_pkg::OP_BITS, '0, '0, 6'd32, 31'd1));
		dir.push_back(mk_fixed(mk(xrs_pkg::OP_BITS, '1, '1, 6'd0, '1), '0)); // zero bit count
		dir.push_back(mk(xrs_pkg::OP_BITS, '0, '0, 6'd1, '0));
		dir.push_back(mk(xrs_pkg::OP_BITS, '0, '0, 6'd63, '0));             // saturates to 32
		dir.push_back(mk(xrs_pkg::OP_BITS, '0, '0, 6'd33, '0));
		dir.push_back(mk(xrs_pkg::OP_LONG, '0, '0, '0, '0));
		dir.push_back(mk_fixed(mk(xrs_pkg::OP_BOUND, '0, '0, '0, 31'd0), '0)); // zero bound
		dir.push_back(mk_fixed(mk(xrs_pkg::OP_BOUND, '0, '0, '0, 31'd1), '0));
		dir.push_back(mk(xrs_pkg::OP_BOUND, '0, '0, '0, 31'h4000_0000));
		dir.push_back(mk(xrs_pkg::OP_BOUND, '0, '0, '0, 31'h7fff_ffff));
		dir.push_back(mk(xrs_pkg::OP_BOUND, '0, '0, '0, 31'h4000_0001));
		dir.push_back(mk(xrs_pkg::OP_BOUND, '0, '0, '0, 31'd3));
		dir.push_back(mk_fixed(mk(xrs_pkg::OP_SEED_PAIR, '0, '0, '0, '0), '0)); // zero pair
		dir.push_back(mk(xrs_pkg::OP_BITS, '0, '0, 6'd32, '0));
		dir.push_back(mk_fixed(mk(xrs_pkg::OP_SEED_PAIR, '1, '1, '1, '1), '0));
		dir.push_back(mk(xrs_pkg::OP_LONG, '0, '0, '0, '0));
		dir.push_back(mk_fixed(mk(xrs_pkg::OP_SEED_PAIR, 64'd1, '0, '0, '0), '0));
		dir.push_back(mk(xrs_pkg::OP_BITS, '0, '0, 6'd16, '0));
		dir.push_back(mk_fixed(mk(xrs_pkg::OP_SEED_MIX, '0, '1, '0, '0), '0));
		dir.push_back(mk(xrs_pkg::OP_LONG, '0, '0, '0, '0));
		dir.push_back(mk_fixed(mk(xrs_pkg::OP_SEED_MIX, '1, '0, '0, '0), '0));
		dir.push_back(mk_fixed(mk(xrs_pkg::OP_JUMP, '1, '1, '1, '1), '0));
		dir.push_back(mk(xrs_pkg::OP_LONG, '0, '0, '0, '0));
		dir.push_back(mk_fixed(mk(OP_SPARE_6, '1, '1, '1, '1), '0));      // unused opcodes
		dir.push_back(mk_fixed(mk(OP_SPARE_7, '1, '1, '1, '1), '0));
		foreach (dir[i])
			send_cmd(dir[i]);

		// Random part in idling phases: none, sender, receiver, both.
		for (int k = 0; k < 1550; k++) begin
			phase = (k * 4) / 1550;
			send_idle = (phase == 1) ? 49 : (phase == 3) ? 36 : 0;
			recv_idle = (phase == 2) ? 49 : (phase == 3) ? 36 : 0;
			// Leave bursts with no idling inside every phase.
			if ((k % 200) < 30) begin
				send_idle = 0;
				recv_idle = 0;
			end
			send_cmd(random_cmd());
		end
		s_tvalid <= 1'b0;
		recv_idle = 0;

		while (value_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("xoroshiro128pp_generator regression: pass");
		else
			$display("xoroshiro128pp_generator regression: fail");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/xrs_pkg.sv
src/xrs_mul.sv
src/xrs_rem.sv
src/xoroshiro128pp_generator.sv
src/xrs_checker.sv
bench/tb_xoroshiro128pp_generator.sv
